[hw/rtl/hte_pkg.sv]
// ----------------------------------------------------------------------------
// hte_pkg
// Shared types and constants of the Huffman table encoder: command codes,
// the code table lookup result and the bit packer result.
// ----------------------------------------------------------------------------
`default_nettype none

package hte_pkg;

  localparam int BYTE_BITS   = 8;
  localparam int LEN_BITS    = 5;
  localparam int RAW_MAX     = 32;
  localparam int MAX_RESULTS = 4;
  // Packer window: 7 pending bits plus up to 32 new bits, byte aligned
  localparam int ACC_BITS    = 40;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_RAW    = 2'd2,
    CMD_FLUSH  = 2'd3
  } cmd_t;

  // Registered code table lookup
  typedef struct packed {
    logic                hit;
    logic [LEN_BITS-1:0] len;
    logic [RAW_MAX-1:0]  code;
  } lookup_t;

  // Packer outcome for one append
  typedef struct packed {
    logic [MAX_RESULTS-1:0][BYTE_BITS-1:0] bytes;
    logic [2:0]                            nbytes;
    logic [BYTE_BITS-2:0]                  new_bits;
    logic [2:0]                            new_count;
    logic [BYTE_BITS-1:0]                  flush_byte;
  } pack_t;

endpackage

`default_nettype wire

[hw/rtl/hte_code_table.sv]
// ----------------------------------------------------------------------------
// hte_code_table
// Code word / length store with per-entry valid bits. Loads are written and
// lookups are read when a transaction is accepted; the lookup is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module hte_code_table
  import hte_pkg::*;
#(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_CODE_LEN = 31
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire cmd_t                 command,
  input  wire logic [BYTE_BITS-1:0] symbol,
  input  wire logic [RAW_MAX-1:0]   field_bits,
  input  wire logic [5:0]           bit_count,
  output lookup_t                   lookup
);

  localparam int IDX_W   = $clog2(SYMBOL_COUNT);
  localparam int ENTRY_W = MAX_CODE_LEN + LEN_BITS;

  logic [ENTRY_W-1:0]      mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] entry_valid;
  logic [ENTRY_W-1:0]      rd_entry;
  logic                    rd_hit;

  logic [IDX_W-1:0] idx;
  logic             in_range;
  logic [5:0]       load_len;
  logic             do_load;

  assign idx      = symbol[IDX_W-1:0];
  assign in_range = {1'b0, symbol} < 9'(SYMBOL_COUNT);
  assign load_len = (bit_count > 6'(MAX_CODE_LEN)) ? 6'(MAX_CODE_LEN) : bit_count;
  assign do_load  = accept && (command == CMD_LOAD) && in_range;

  // Table storage: one write or one read per accepted transaction
  always_ff @(posedge clk) begin
    if (do_load) begin
      mem[idx] <= {field_bits[MAX_CODE_LEN-1:0], load_len[LEN_BITS-1:0]};
    end else if (accept) begin
      rd_entry <= mem[idx];
    end
  end

  // Valid bits and registered hit flag
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_hit      <= 1'b0;
    end else if (do_load) begin
      entry_valid[idx] <= 1'b1;
    end else if (accept) begin
      rd_hit <= in_range && entry_valid[idx];
    end
  end

  assign lookup.hit  = rd_hit;
  assign lookup.len  = rd_entry[LEN_BITS-1:0];
  assign lookup.code = RAW_MAX'(rd_entry[ENTRY_W-1:LEN_BITS]);

endmodule

`default_nettype wire

[hw/rtl/hte_bit_packer.sv]
// ----------------------------------------------------------------------------
// hte_bit_packer
// MSB-first packer datapath: merges the pending partial byte with up to 32
// new bits, splits out the completed bytes and the new partial byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hte_bit_packer
  import hte_pkg::*;
(
  input  wire logic [BYTE_BITS-2:0] pending_bits,
  input  wire logic [2:0]           pending_count,
  input  wire logic [RAW_MAX-1:0]   bits,
  input  wire logic [5:0]           count,
  output pack_t                     result
);

  logic [ACC_BITS-1:0]  p_top;
  logic [ACC_BITS-1:0]  b_top;
  logic [ACC_BITS-1:0]  acc;
  logic [5:0]           total;
  logic [2:0]           rem;
  logic [BYTE_BITS-2:0] tail;

  // Left-align pending bits, then the low 'count' new bits right behind them
  assign p_top = {pending_bits, 33'b0} << (3'd7 - pending_count);
  assign b_top = {bits, 8'b0} << (6'd32 - count);
  assign acc   = p_top | (b_top >> pending_count);
  assign total = 6'(pending_count) + count;
  assign rem   = total[2:0];

  // Bits left over after the completed bytes
  always_comb begin
    case (total[5:3])
      3'd0:    tail = acc[39:33];
      3'd1:    tail = acc[31:25];
      3'd2:    tail = acc[23:17];
      3'd3:    tail = acc[15:9];
      3'd4:    tail = acc[7:1];
      default: tail = '0;
    endcase
  end

  // Completed bytes come off the top of the window; the rest is the new tail
  always_comb begin
    for (int j = 0; j < MAX_RESULTS; j++) begin
      result.bytes[j] = acc[ACC_BITS-1-BYTE_BITS*j -: BYTE_BITS];
    end
    result.nbytes     = total[5:3];
    result.new_bits   = tail >> (3'd7 - rem);
    result.new_count  = rem;
    result.flush_byte = p_top[ACC_BITS-1 -: BYTE_BITS];
  end

endmodule

`default_nettype wire

[hw/rtl/huffman_table_encoder.sv]
// ----------------------------------------------------------------------------
// huffman_table_encoder
// Table-driven Huffman encoder with an MSB-first byte packer.
// ----------------------------------------------------------------------------
// Commands: load a code table entry, encode a symbol, append raw bits, flush
// the partial byte. A transaction is accepted every cycle as long as the
// result side keeps up; the code table lookup is registered alongside the
// transaction register, the packer works on that register, and the result
// bytes are registered into the result group. Results leave one byte per
// cycle while out_ready is high, so a transaction that completes k bytes (at
// most four) holds the result port until all k are taken, and the sustained
// rate is set by that port. Loads and transactions that emit no result byte
// never wait for the result port. The valid bits are cleared by reset at
// once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_table_encoder
  import hte_pkg::*;
#(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_CODE_LEN = 31
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic [1:0]           command,
  input  wire logic [BYTE_BITS-1:0] symbol,
  input  wire logic [RAW_MAX-1:0]   field_bits,
  input  wire logic [5:0]           bit_count,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic [BYTE_BITS-1:0] out_byte,
  output      logic                 status,
  output      logic                 last_of_run
);

  logic    in_fire;
  lookup_t lookup;

  // Transaction register (table lookup lands alongside)
  logic               s1_valid;
  cmd_t               s1_cmd;
  logic [RAW_MAX-1:0] s1_field;
  logic [5:0]         s1_count;
  logic               s1_advance;

  // Packer state
  logic [BYTE_BITS-2:0] pending_bits, pending_bits_next;
  logic [2:0]           pending_count, pending_count_next;

  // Result group being drained
  logic                                  grp_valid;
  logic [MAX_RESULTS-1:0][BYTE_BITS-1:0] grp_bytes;
  logic                                  grp_status;
  logic [1:0]                            grp_last;
  logic [1:0]                            grp_idx;
  logic                                  grp_free;

  // Packer hookup and result selection
  logic [RAW_MAX-1:0]                    pk_bits;
  logic [5:0]                            pk_count;
  pack_t                                 pk;
  logic [2:0]                            nres;
  logic [MAX_RESULTS-1:0][BYTE_BITS-1:0] res_bytes;
  logic                                  res_status;

  assign in_fire  = in_valid && in_ready;
  assign in_ready = !s1_valid || s1_advance;

  hte_code_table #(
    .SYMBOL_COUNT(SYMBOL_COUNT),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_fire),
    .command   (cmd_t'(command)),
    .symbol    (symbol),
    .field_bits(field_bits),
    .bit_count (bit_count),
    .lookup    (lookup)
  );

  // Transaction register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_fire) begin
      s1_cmd   <= cmd_t'(command);
      s1_field <= field_bits;
      s1_count <= bit_count;
    end
  end

  // Packer input select: code word for encode, literal bits for raw
  always_comb begin
    if (s1_cmd == CMD_ENCODE) begin
      pk_bits  = lookup.code;
      pk_count = {1'b0, lookup.len};
    end else begin
      pk_bits  = s1_field;
      pk_count = (s1_count > 6'(RAW_MAX)) ? 6'(RAW_MAX) : s1_count;
    end
  end

  hte_bit_packer u_packer (
    .pending_bits (pending_bits),
    .pending_count(pending_count),
    .bits         (pk_bits),
    .count        (pk_count),
    .result       (pk)
  );

  // Command decode: result bytes and next packer state
  always_comb begin
    nres               = 3'd0;
    res_bytes          = pk.bytes;
    res_status         = 1'b0;
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    unique case (s1_cmd)
      CMD_LOAD: begin
      end
      CMD_ENCODE: begin
        if (lookup.hit) begin
          nres               = pk.nbytes;
          pending_bits_next  = pk.new_bits;
          pending_count_next = pk.new_count;
        end else begin
          nres       = 3'd1;
          res_bytes  = '0;
          res_status = 1'b1;
        end
      end
      CMD_RAW: begin
        nres               = pk.nbytes;
        pending_bits_next  = pk.new_bits;
        pending_count_next = pk.new_count;
      end
      CMD_FLUSH: begin
        if (pending_count != 3'd0) begin
          nres               = 3'd1;
          res_bytes          = '0;
          res_bytes[0]       = pk.flush_byte;
          pending_bits_next  = '0;
          pending_count_next = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Result group frees up as its last byte is taken
  assign grp_free   = !grp_valid || (out_ready && (grp_idx == grp_last));
  assign s1_advance = s1_valid && ((nres == 3'd0) || grp_free);

  // Packer state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
    end else if (s1_advance) begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

  // Result group: load from the packer, drain one byte per accepted output byte
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      grp_idx   <= '0;
    end else if (s1_advance && (nres != 3'd0)) begin
      grp_valid <= 1'b1;
      grp_idx   <= '0;
    end else if (grp_valid && out_ready) begin
      if (grp_idx == grp_last) begin
        grp_valid <= 1'b0;
      end else begin
        grp_idx <= grp_idx + 2'd1;
      end
    end
    if (s1_advance && (nres != 3'd0)) begin
      grp_bytes  <= res_bytes;
      grp_status <= res_status;
      grp_last   <= 2'(nres - 3'd1);
    end
  end

  assign out_valid   = grp_valid;
  assign out_byte    = grp_bytes[grp_idx];
  assign status      = grp_status;
  assign last_of_run = (grp_idx == grp_last);

endmodule

`default_nettype wire
